// ----- sv/four_wheel_incremental_pd_drive_core_defines.svh -----
// Assertion helpers used by the checker file fwpd_chk.
`ifndef FOUR_WHEEL_INCREMENTAL_PD_DRIVE_CORE_DEFINES_SVH
`define FOUR_WHEEL_INCREMENTAL_PD_DRIVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FWPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwpd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FWPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwpd assertion failed");

`endif

// ----- sv/fwpd_pkg.sv -----
`default_nettype none
package fwpd_pkg;

  localparam int WHEELS      = 4;
  localparam int WHEEL_W     = $clog2(WHEELS);
  localparam int DRIVE_LIMIT = 2000;
  localparam int FRAC_BITS   = 12;

  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int DRIVE_W   = 12;
  localparam int COMPARE_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd800;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd400;

  typedef logic        [1:0]           wheel_t;
  typedef logic        [WHEEL_W-1:0]   widx_t;
  typedef logic signed [SPEED_W-1:0]   speed_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic signed [ERR_W-1:0]     err_t;
  typedef logic signed [DRIVE_W-1:0]   drive_t;
  typedef logic        [COMPARE_W-1:0] compare_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_DERIV_GAIN = 2'd1
  } reg_idx_t;

  typedef struct packed {
    drive_t   drive;
    compare_t compare;
    logic     reverse;
    err_t     err;
  } calc_res_t;

endpackage
`default_nettype wire

// ----- sv/four_wheel_incremental_pd_drive_core.sv -----
// Four-wheel incremental PD drive core. Each input beat names a wheel and
// carries target and measured speed (signed Q4.12); the core forms the speed
// error, adds (prop_gain*error + deriv_gain*(error - last error)) / 4096,
// truncated toward zero, to that wheel's drive accumulator, saturates it to
// +-2000 and returns one result beat: wheel, drive, PWM compare value
// (drive, or 2000 + drive when negative) and the reverse bit. Throughput is
// one beat per clock while out_ready does not stall. A beat passes from the
// input register to the result register through a single pass of two
// multipliers, an adder and the clamp. Per-wheel state is written when a
// beat leaves the input register, so back-to-back beats for the same wheel
// see the updated accumulator. Gains are written through the cfg port
// (index 0 prop_gain, index 1 deriv_gain, other indexes ignored); the user
// must write them only while idle, which the core does not enforce. Reset
// restores gains 800 and 400 and clears all wheel state.
`default_nettype none
module four_wheel_incremental_pd_drive_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  fwpd_pkg::wheel_t           in_wheel,
  input  fwpd_pkg::speed_t           in_target_speed,
  input  fwpd_pkg::speed_t           in_measured_speed,
  output logic                       out_valid,
  input  wire                        out_ready,
  output fwpd_pkg::wheel_t           out_wheel_out,
  output fwpd_pkg::drive_t           out_drive,
  output fwpd_pkg::compare_t         out_compare,
  output logic                       out_reverse,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  fwpd_pkg::cfg_idx_t         cfg_index,
  input  fwpd_pkg::gain_t            cfg_data
);
  import fwpd_pkg::*;

  // gain registers
  gain_t   kp_r;
  gain_t   kd_r;

  // input stage
  logic    s1_v_r;
  widx_t   s1_widx_r;
  speed_t  s1_tgt_r;
  speed_t  s1_meas_r;

  // per-wheel state
  drive_t  drive_r [WHEELS];
  err_t    lerr_r  [WHEELS];

  // result stage
  logic     out_v_r;
  widx_t    out_widx_r;
  drive_t   out_drive_r;
  compare_t out_cmp_r;
  logic     out_rev_r;

  logic      advance;
  calc_res_t res;

  // The result register frees up when empty or when its beat is taken.
  assign advance   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || advance;
  assign cfg_ready = 1'b1;

  // Config writes: decode the index, drop unknown ones.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= PROP_GAIN_RST;
      kd_r <= DERIV_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  kp_r <= cfg_data;
        REG_DERIV_GAIN: kd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold while the pipe is stalled, load on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      // wheel index wraps modulo WHEELS
      s1_widx_r <= in_wheel[WHEEL_W-1:0];
      s1_tgt_r  <= in_target_speed;
      s1_meas_r <= in_measured_speed;
    end
  end

  fwpd_calc u_calc (
    .target   (s1_tgt_r),
    .measured (s1_meas_r),
    .last_err (lerr_r[s1_widx_r]),
    .drive_in (drive_r[s1_widx_r]),
    .kp       (kp_r),
    .kd       (kd_r),
    .res      (res)
  );

  // Wheel state: commit the new drive and error as the beat advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) begin
        drive_r[i] <= '0;
        lerr_r[i]  <= '0;
      end
    end else if (advance) begin
      drive_r[s1_widx_r] <= res.drive;
      lerr_r[s1_widx_r]  <= res.err;
    end
  end

  // Result register: valid clears once taken unless a new beat arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_widx_r  <= s1_widx_r;
      out_drive_r <= res.drive;
      out_cmp_r   <= res.compare;
      out_rev_r   <= res.reverse;
    end
  end

  assign out_valid     = out_v_r;
  assign out_wheel_out = 2'(out_widx_r);
  assign out_drive     = out_drive_r;
  assign out_compare   = out_cmp_r;
  assign out_reverse   = out_rev_r;

endmodule
`default_nettype wire

// ----- sv/fwpd_calc.sv -----
`default_nettype none
module fwpd_calc (
  input  fwpd_pkg::speed_t   target,
  input  fwpd_pkg::speed_t   measured,
  input  fwpd_pkg::err_t     last_err,
  input  fwpd_pkg::drive_t   drive_in,
  input  fwpd_pkg::gain_t    kp,
  input  fwpd_pkg::gain_t    kd,
  output fwpd_pkg::calc_res_t res
);
  import fwpd_pkg::*;

  localparam int DERR_W  = ERR_W + 1;
  localparam int SUM_W   = GAIN_W + DERR_W + 1;
  localparam int DELTA_W = SUM_W - FRAC_BITS;
  localparam int ACC_W   = DELTA_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  err_t                      err;
  logic signed [DERR_W-1:0]  derr;
  logic signed [SUM_W-1:0]   p_prod;
  logic signed [SUM_W-1:0]   d_prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   biased;
  logic signed [SUM_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_c;

  always_comb begin
    err    = ERR_W'(target) - ERR_W'(measured);
    derr   = DERR_W'(err) - DERR_W'(last_err);
    p_prod = SUM_W'(kp) * SUM_W'(err);
    d_prod = SUM_W'(kd) * SUM_W'(derr);
    sum    = p_prod + d_prod;
    // bias negative sums so the arithmetic shift truncates toward zero
    biased  = sum[SUM_W-1] ? (sum + ROUND_BIAS) : sum;
    shifted = biased >>> FRAC_BITS;
    acc     = ACC_W'(drive_in) + ACC_W'($signed(shifted[DELTA_W-1:0]));
    if (acc > ACC_W'(DRIVE_LIMIT)) begin
      acc_c = ACC_W'(DRIVE_LIMIT);
    end else if (acc < -ACC_W'(DRIVE_LIMIT)) begin
      acc_c = -ACC_W'(DRIVE_LIMIT);
    end else begin
      acc_c = acc;
    end
    res.drive   = DRIVE_W'(acc_c);
    res.reverse = acc_c[ACC_W-1];
    res.compare = acc_c[ACC_W-1] ? COMPARE_W'(DRIVE_LIMIT + 32'(acc_c))
                                 : COMPARE_W'(acc_c);
    res.err     = err;
  end

endmodule
`default_nettype wire

// ----- sv/fwpd_chk.sv -----
`default_nettype none
`include "four_wheel_incremental_pd_drive_core_defines.svh"
module fwpd_chk (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input fwpd_pkg::wheel_t     in_wheel,
  input fwpd_pkg::speed_t     in_target_speed,
  input fwpd_pkg::speed_t     in_measured_speed,
  input wire                  out_valid,
  input wire                  out_ready,
  input fwpd_pkg::wheel_t     out_wheel_out,
  input fwpd_pkg::drive_t     out_drive,
  input fwpd_pkg::compare_t   out_compare,
  input wire                  out_reverse,
  input wire                  cfg_valid,
  input wire                  cfg_ready,
  input fwpd_pkg::cfg_idx_t   cfg_index,
  input fwpd_pkg::gain_t      cfg_data
);
  import fwpd_pkg::*;

  // a stalled result beat holds
  `FWPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive) && $stable(out_compare) && $stable(out_wheel_out))
  // drive stays within the clamp
  `FWPD_ASSERT_NOW(a_drive_range, out_valid, (out_drive <= 12'sd2000) && (out_drive >= -12'sd2000))
  // reverse tracks the sign of drive
  `FWPD_ASSERT_NOW(a_rev_sign, out_valid, out_reverse == out_drive[DRIVE_W-1])
  // compare follows the set-speed mapping
  `FWPD_ASSERT_NOW(a_cmp_map, out_valid, (!out_reverse && (out_compare == COMPARE_W'(out_drive))) || (out_reverse && (out_compare == COMPARE_W'(32'(out_drive) + DRIVE_LIMIT))))

endmodule

bind four_wheel_incremental_pd_drive_core fwpd_chk u_fwpd_chk (.*);
`default_nettype wire

// ----- verif/fwpd_drive_checker.sv -----
`timescale 1ns / 100ps
module fwpd_drive_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  fwpd_pkg::wheel_t   in_wheel,
  input  fwpd_pkg::speed_t   in_target_speed,
  input  fwpd_pkg::speed_t   in_measured_speed,
  input  wire                out_valid,
  input  wire                out_ready,
  input  fwpd_pkg::wheel_t   out_wheel_out,
  input  fwpd_pkg::drive_t   out_drive,
  input  fwpd_pkg::compare_t out_compare,
  input  wire                out_reverse,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  fwpd_pkg::cfg_idx_t cfg_index,
  input  fwpd_pkg::gain_t    cfg_data,
  output int                 mismatch_count,
  output int                 drive_pending
);
  import fwpd_pkg::*;

  typedef struct packed {
    wheel_t   wheel;
    drive_t   drive;
    compare_t compare;
    logic     reverse;
  } drive_beat_t;

  gain_t       kp;
  gain_t       kd;
  drive_t      drive_acc [WHEELS];
  err_t        last_err  [WHEELS];
  drive_beat_t drive_expect_q [$];

  initial mismatch_count = 0;
  initial drive_pending  = 0;

  // Advance one wheel's accumulator and return the beat it should produce.
  function automatic drive_beat_t step_wheel(wheel_t w, speed_t tgt, speed_t meas);
    widx_t                 i;
    err_t                  err;
    logic signed [ERR_W:0] derr;
    longint                sum;
    longint                acc;
    drive_beat_t           r;
    i    = widx_t'(w % WHEELS);
    err  = err_t'(tgt) - err_t'(meas);
    derr = err - last_err[i];
    sum  = longint'(kp) * longint'(err) + longint'(kd) * longint'(derr);
    // SV signed division truncates toward zero, as the shift is defined here
    acc  = longint'(drive_acc[i]) + sum / (longint'(1) <<< FRAC_BITS);
    if (acc > DRIVE_LIMIT) acc = DRIVE_LIMIT;
    if (acc < -DRIVE_LIMIT) acc = -DRIVE_LIMIT;
    drive_acc[i] = drive_t'(acc);
    last_err[i]  = err;
    r.wheel   = wheel_t'(i);
    r.drive   = drive_t'(acc);
    r.compare = compare_t'(acc >= 0 ? acc : DRIVE_LIMIT + acc);
    r.reverse = (acc < 0);
    return r;
  endfunction

  always @(posedge clk) begin : track
    drive_beat_t got;
    drive_beat_t want;
    int          k;
    if (!rst_n) begin
      kp = PROP_GAIN_RST;
      kd = DERIV_GAIN_RST;
      for (k = 0; k < WHEELS; k++) begin
        drive_acc[k] = '0;
        last_err[k]  = '0;
      end
      drive_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:  kp = cfg_data;
          REG_DERIV_GAIN: kd = cfg_data;
          default: ;  // unknown index: drop the write
        endcase
      end
      if (in_valid && in_ready)
        drive_expect_q.push_back(step_wheel(in_wheel, in_target_speed, in_measured_speed));
      if (out_valid && out_ready) begin
        got = '{out_wheel_out, out_drive, out_compare, out_reverse};
        if (drive_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result beat: wheel %0d drive %0d compare %0d reverse %0b",
                     $time, got.wheel, $signed(got.drive), got.compare, got.reverse);
        end else begin
          want = drive_expect_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: result mismatch: wheel exp %0d got %0d, drive exp %0d got %0d, ",
                        "compare exp %0d got %0d, reverse exp %0b got %0b"},
                       $time, want.wheel, got.wheel, $signed(want.drive), $signed(got.drive),
                       want.compare, got.compare, want.reverse, got.reverse);
          end
        end
      end
    end
    drive_pending = drive_expect_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import fwpd_pkg::*;

  // Cycles without any beat on any channel before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus a receiver stall plus
  // the pass through the input and result registers, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 66;

  // Register indexes the core does not decode; writes there must be dropped.
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  wheel_t   in_wheel;
  speed_t   in_target_speed;
  speed_t   in_measured_speed;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wheel_t   out_wheel_out;
  drive_t   out_drive;
  compare_t out_compare;
  logic     out_reverse;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  gain_t    cfg_data;

  int       mismatch_count;
  int       drive_pending;
  int       quiet_cycles = 0;
  int       rx_hold = 0;
  bit       calm = 1'b0;    // set for the closing stretch: no idling on either side

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  four_wheel_incremental_pd_drive_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_wheel          (in_wheel),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wheel_out     (out_wheel_out),
    .out_drive         (out_drive),
    .out_compare       (out_compare),
    .out_reverse       (out_reverse),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  fwpd_drive_checker drive_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_wheel          (in_wheel),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wheel_out     (out_wheel_out),
    .out_drive         (out_drive),
    .out_compare       (out_compare),
    .out_reverse       (out_reverse),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .drive_pending     (drive_pending)
  );

  // Result side: stall in random bursts, never while calm.
  // One assignment to out_ready per falling edge.
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_hold   <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: reset the count on any beat, give up after too long a silence.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** four_wheel_incremental_pd_drive_core: FAILED **");
        $finish;
      end
    end
  end

  // Present one input beat at a falling edge and hold it until accepted.
  // Valid is left high on return so a following beat rides back to back;
  // whoever stops sending lowers it.
  task automatic send_beat(wheel_t w, speed_t tgt, speed_t meas);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_wheel          <= w;
    in_target_speed   <= tgt;
    in_measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result beat has come back.
  // Always wait for a falling edge so valid is not raised in the same step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (drive_pending != 0);
  endtask

  // One register write beat; call only with the core idle.
  task automatic write_reg(cfg_idx_t idx, gain_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly closed-loop-like beats: measured speed near target with an error
  // whose scale is picked at random, so both tracking and saturation show up.
  // The rest is full-range noise on both speeds.
  task automatic send_random_beat();
    wheel_t w;
    speed_t tgt;
    speed_t meas;
    int     shift;
    int     delta;
    w   = wheel_t'($urandom);
    tgt = speed_t'($urandom);
    if ($urandom_range(0, 9) < 4) begin
      meas = speed_t'($urandom);
    end else begin
      shift = $urandom_range(0, 11);
      delta = int'($urandom_range(0, 2 << shift)) - (1 << shift);
      meas  = speed_t'(int'(tgt) + delta);
    end
    send_beat(w, tgt, meas);
  endtask

  initial begin : stimulus
    gain_t kp_tab [PHASES];
    gain_t kd_tab [PHASES];
    int    p;
    int    n;
    int    pause_at;

    in_valid          = 1'b0;
    in_wheel          = '0;
    in_target_speed   = '0;
    in_measured_speed = '0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_PROP_GAIN;
    cfg_data          = '0;
    rst_n             = 1'b0;

    // Gain settings per phase: both extremes, zero, unit, random, stock.
    kp_tab[0] = 16'sh7fff;                  kd_tab[0] = 16'sh8000;
    kp_tab[1] = 16'sh8000;                  kd_tab[1] = 16'sh7fff;
    kp_tab[2] = '0;                         kd_tab[2] = '0;
    kp_tab[3] = 16'sd1;                     kd_tab[3] = -16'sd1;
    kp_tab[4] = gain_t'($urandom);          kd_tab[4] = gain_t'($urandom);
    kp_tab[5] = gain_t'($urandom);          kd_tab[5] = gain_t'($urandom);
    kp_tab[6] = gain_t'($urandom_range(0, 8191) - 4096);
    kd_tab[6] = gain_t'($urandom_range(0, 8191) - 4096);
    kp_tab[7] = PROP_GAIN_RST;              kd_tab[7] = DERIV_GAIN_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats at the reset gains (800 / 400).
    // Largest positive error, then hold: pin at +2000.
    send_beat(2'd0, 16'sh7fff, 16'sh8000);
    send_beat(2'd0, 16'sh7fff, 16'sh8000);
    // Largest negative error: swing to -2000, compare 0, reverse set.
    send_beat(2'd0, 16'sh8000, 16'sh7fff);
    // Tiny errors: the update truncates to zero in both signs.
    send_beat(2'd1, 16'sd0, 16'sd0);
    send_beat(2'd1, 16'sd1, 16'sd0);
    send_beat(2'd1, 16'sd0, 16'sd1);
    send_beat(2'd1, 16'sd0, 16'sd1);
    // Small swings around zero drive on one wheel, one beat after another.
    send_beat(2'd2, 16'sd100, 16'sd0);
    send_beat(2'd2, -16'sd100, 16'sd0);
    send_beat(2'd2, 16'sd0, 16'sd0);
    send_beat(2'd2, 16'sd0, 16'sd0);
    // Walk wheel 3 onto +2000 exactly, past it, then down onto -2000 exactly.
    send_beat(2'd3, 16'sd4096, 16'sd0);
    send_beat(2'd3, 16'sd4096, 16'sd0);
    send_beat(2'd3, 16'sd4096, 16'sd0);
    send_beat(2'd3, -16'sd4096, 16'sd0);
    send_beat(2'd3, -16'sd8192, 16'sd0);
    send_beat(2'd3, -16'sd4096, 16'sd0);
    send_beat(2'd3, 16'sd0, 16'sd0);
    // Zero error with extreme speeds on wheels 0 to 2.
    send_beat(2'd0, -16'sd1, -16'sd1);
    send_beat(2'd1, 16'sh8000, 16'sh8000);
    send_beat(2'd2, 16'sh7fff, 16'sh7fff);
    wait_drained();

    // Writes to undecoded indexes must leave both gains alone.
    write_reg(REG_SPARE_2, 16'sh7fff);
    write_reg(REG_SPARE_3, 16'sh8000);
    send_beat(2'd0, 16'sd100, 16'sd0);
    send_beat(2'd1, 16'sd100, 16'sd0);

    // Random phases, each under its own gain setting. Drain before each
    // register write; also drain once at a random point inside each phase.
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_PROP_GAIN, kp_tab[p]);
      write_reg(REG_DERIV_GAIN, kd_tab[p]);
      if (p == PHASES - 1) calm = 1'b1;
      pause_at = $urandom_range(5, PHASE_BEATS - 5);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (n == pause_at) wait_drained();
        send_random_beat();
      end
    end

    // Let the last results out, then idle on past the pipeline before the verdict.
    wait_drained();
    repeat (8) @(negedge clk);

    if (mismatch_count == 0 && drive_pending == 0) begin
      $display("** four_wheel_incremental_pd_drive_core: PASSED **");
    end else begin
      $display("** four_wheel_incremental_pd_drive_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fwpd_pkg.sv
sv/fwpd_calc.sv
sv/four_wheel_incremental_pd_drive_core.sv
sv/fwpd_chk.sv
verif/fwpd_drive_checker.sv
verif/tb_top.sv
